@@ hw/rtl/pnp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnp_pkg
// Shared widths, row kind codes and the structs that pass between the
// sequencer, the compare unit and the output stage.
// ----------------------------------------------------------------------------
package pnp_pkg;

	localparam int VAL_W  = 16;
	localparam int KIND_W = 2;

	// row kind codes on row_kind
	localparam logic [KIND_W-1:0] KIND_PREV = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ORIG = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT = 2'd2;

	// result of the shared compare unit
	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_t;

	// one result element handed from the sequencer to the output register
	typedef struct packed {
		logic              load;
		logic [VAL_W-1:0]  value;
		logic [KIND_W-1:0] kind;
		logic              row_end;
		logic              last;
	} emit_t;

endpackage

@@ hw/rtl/pnp_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnp_cmp
// Shared unsigned magnitude compare, used for the pivot scan, the swap
// partner search and the reverse-loop bound test.
// ----------------------------------------------------------------------------
module pnp_cmp (
	input  logic [pnp_pkg::VAL_W-1:0] a,
	input  logic [pnp_pkg::VAL_W-1:0] b,
	output pnp_pkg::cmp_t             res
);
	import pnp_pkg::*;

	// compare a against b
	always_comb begin
		res.lt = (a < b);
		res.gt = (a > b);
	end

endmodule

@@ hw/rtl/pnp_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnp_seq
// Sequencer with the element store and the scratch row. Loads the sequence,
// then walks the scratch row through the shared compare unit to form the
// previous and next permutations, and streams the rows out one element at
// a time.
// ----------------------------------------------------------------------------
module pnp_seq #(
	parameter int MAX_LEN = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [pnp_pkg::VAL_W-1:0] value,
	input  logic                      is_last,
	output logic                      in_stall,
	input  logic                      out_free,
	output pnp_pkg::emit_t            emit
);
	import pnp_pkg::*;

	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_PSTART   = 4'd1;
	localparam logic [3:0] ST_SCAN_RD  = 4'd2;
	localparam logic [3:0] ST_SCAN_CMP = 4'd3;
	localparam logic [3:0] ST_FIND_RD  = 4'd4;
	localparam logic [3:0] ST_FIND_CMP = 4'd5;
	localparam logic [3:0] ST_SWAP_W1  = 4'd6;
	localparam logic [3:0] ST_SWAP_W2  = 4'd7;
	localparam logic [3:0] ST_REV_RD   = 4'd8;
	localparam logic [3:0] ST_REV_W1   = 4'd9;
	localparam logic [3:0] ST_REV_W2   = 4'd10;
	localparam logic [3:0] ST_AFTER    = 4'd11;
	localparam logic [3:0] ST_EMIT_RD  = 4'd12;
	localparam logic [3:0] ST_EMIT_WR  = 4'd13;
	localparam logic [3:0] ST_COPY_RD  = 4'd14;
	localparam logic [3:0] ST_COPY_WR  = 4'd15;

	// control state
	logic [3:0]        state_q;
	logic [CW-1:0]     count_q;
	logic              dir_q;       // 0 previous, 1 next
	logic              ok_q;        // permutation exists
	logic [KIND_W-1:0] kind_q;

	// working registers
	logic [CW-1:0]    n_q;
	logic [IW-1:0]    i_q;
	logic [IW-1:0]    j_q;
	logic [IW-1:0]    lo_q;
	logic [IW-1:0]    hi_q;
	logic [IW-1:0]    e_q;
	logic [IW-1:0]    piv_q;
	logic [VAL_W-1:0] piv_val_q;
	logic [VAL_W-1:0] jv_q;

	// memories
	logic [VAL_W-1:0] elem_mem [MAX_LEN];
	logic [VAL_W-1:0] work_mem [MAX_LEN];
	logic [VAL_W-1:0] elem_rd_q;
	logic [VAL_W-1:0] work_rda_q;
	logic [VAL_W-1:0] work_rdb_q;

	logic             accept;
	logic             room;
	logic [IW-1:0]    n_m1;
	logic             work_we;
	logic [IW-1:0]    work_wa;
	logic [VAL_W-1:0] work_wd;
	logic [IW-1:0]    work_raa;
	logic [IW-1:0]    work_rab;
	logic [VAL_W-1:0] cmp_a;
	logic [VAL_W-1:0] cmp_b;
	cmp_t             cmp_res;
	logic             hit;
	logic             row_end;

	assign in_stall = (state_q != ST_LOAD);
	assign accept   = in_valid && !in_stall;
	assign room     = (count_q < CW'(MAX_LEN));
	assign n_m1     = IW'(n_q - CW'(1));
	assign row_end  = (e_q == n_m1);

	// element store: written while loading, read for copy and original row
	always_ff @(posedge clk) begin
		if (accept && room) begin
			elem_mem[count_q[IW-1:0]] <= value;
		end
		elem_rd_q <= elem_mem[e_q];
	end

	// scratch row: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (work_we) begin
			work_mem[work_wa] <= work_wd;
		end
		work_rda_q <= work_mem[work_raa];
		work_rdb_q <= work_mem[work_rab];
	end

	// select scratch row addresses and write data
	always_comb begin
		work_we  = 1'b0;
		work_wa  = e_q;
		work_wd  = elem_rd_q;
		work_raa = e_q;
		work_rab = hi_q;
		unique case (state_q)
			ST_LOAD: begin
				work_we = accept && room;
				work_wa = count_q[IW-1:0];
				work_wd = value;
			end
			ST_SCAN_RD, ST_SCAN_CMP: begin
				work_raa = IW'(i_q - IW'(1));
				work_rab = i_q;
			end
			ST_FIND_RD, ST_FIND_CMP: begin
				work_raa = j_q;
			end
			ST_SWAP_W1: begin
				work_we = 1'b1;
				work_wa = piv_q;
				work_wd = jv_q;
			end
			ST_SWAP_W2: begin
				work_we = 1'b1;
				work_wa = j_q;
				work_wd = piv_val_q;
			end
			ST_REV_RD: begin
				work_raa = lo_q;
			end
			ST_REV_W1: begin
				work_raa = lo_q;
				work_we  = 1'b1;
				work_wa  = lo_q;
				work_wd  = work_rdb_q;
			end
			ST_REV_W2: begin
				work_raa = lo_q;
				work_we  = 1'b1;
				work_wa  = hi_q;
				work_wd  = work_rda_q;
			end
			ST_COPY_WR: begin
				work_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// steer operands into the shared compare unit
	always_comb begin
		cmp_a = work_rda_q;
		cmp_b = work_rdb_q;
		hit   = 1'b0;
		unique case (state_q)
			ST_SCAN_CMP: begin
				hit = dir_q ? cmp_res.lt : cmp_res.gt;
			end
			ST_FIND_CMP: begin
				cmp_b = piv_val_q;
				hit   = dir_q ? cmp_res.gt : cmp_res.lt;
			end
			ST_REV_RD: begin
				cmp_a = VAL_W'(lo_q);
				cmp_b = VAL_W'(hi_q);
				hit   = cmp_res.lt;
			end
			default: begin
			end
		endcase
	end

	pnp_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// form one result element
	always_comb begin
		emit.load    = (state_q == ST_EMIT_WR) && out_free;
		emit.value   = (kind_q == KIND_ORIG) ? elem_rd_q : work_rda_q;
		emit.kind    = kind_q;
		emit.row_end = row_end;
		emit.last    = row_end && ((kind_q == KIND_NEXT) || ((kind_q == KIND_ORIG) && !ok_q));
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			dir_q   <= 1'b0;
			ok_q    <= 1'b0;
			kind_q  <= KIND_ORIG;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end
						if (is_last) begin
							n_q     <= room ? count_q + CW'(1) : count_q;
							dir_q   <= 1'b0;
							state_q <= ST_PSTART;
						end
					end
				end
				ST_PSTART: begin
					if (n_q == CW'(1)) begin
						ok_q    <= 1'b0;
						state_q <= ST_AFTER;
					end else begin
						i_q     <= n_m1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					if (hit) begin
						piv_q     <= IW'(i_q - IW'(1));
						piv_val_q <= work_rda_q;
						j_q       <= n_m1;
						state_q   <= ST_FIND_RD;
					end else if (i_q == IW'(1)) begin
						ok_q    <= 1'b0;
						state_q <= ST_AFTER;
					end else begin
						i_q     <= IW'(i_q - IW'(1));
						state_q <= ST_SCAN_RD;
					end
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_CMP;
				end
				ST_FIND_CMP: begin
					if (hit) begin
						jv_q    <= work_rda_q;
						state_q <= ST_SWAP_W1;
					end else begin
						j_q     <= IW'(j_q - IW'(1));
						state_q <= ST_FIND_RD;
					end
				end
				ST_SWAP_W1: begin
					state_q <= ST_SWAP_W2;
				end
				ST_SWAP_W2: begin
					lo_q    <= IW'(piv_q + IW'(1));
					hi_q    <= n_m1;
					state_q <= ST_REV_RD;
				end
				ST_REV_RD: begin
					if (hit) begin
						state_q <= ST_REV_W1;
					end else begin
						ok_q    <= 1'b1;
						state_q <= ST_AFTER;
					end
				end
				ST_REV_W1: begin
					state_q <= ST_REV_W2;
				end
				ST_REV_W2: begin
					lo_q    <= IW'(lo_q + IW'(1));
					hi_q    <= IW'(hi_q - IW'(1));
					state_q <= ST_REV_RD;
				end
				ST_AFTER: begin
					e_q <= '0;
					if (!dir_q) begin
						kind_q  <= KIND_PREV;
						state_q <= ok_q ? ST_EMIT_RD : ST_COPY_RD;
					end else begin
						kind_q  <= KIND_ORIG;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						if (!row_end) begin
							e_q     <= IW'(e_q + IW'(1));
							state_q <= ST_EMIT_RD;
						end else begin
							e_q <= '0;
							priority if (kind_q == KIND_PREV) begin
								state_q <= ST_COPY_RD;
							end else if ((kind_q == KIND_ORIG) && ok_q) begin
								kind_q  <= KIND_NEXT;
								state_q <= ST_EMIT_RD;
							end else begin
								count_q <= '0;
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_COPY_RD: begin
					state_q <= ST_COPY_WR;
				end
				ST_COPY_WR: begin
					if (row_end) begin
						dir_q   <= 1'b1;
						state_q <= ST_PSTART;
					end else begin
						e_q     <= IW'(e_q + IW'(1));
						state_q <= ST_COPY_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/prev_next_permutation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prev_next_permutation
// Lexicographic previous and next permutation of a loaded sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one element per transaction, is_last
//   on the final one. Loading takes one cycle per element; elements past
//   MAX_LEN are dropped, but their is_last mark still ends the sequence.
//   After is_last, in_stall stays high while the sequencer works: the pivot
//   scan, partner search and suffix reversal each step through the scratch
//   row with one shared comparator and one write port.
//   Output channel (out_valid / out_stall): the previous row (if any), the
//   original row, then the next row (if any), one element per transaction,
//   tagged by row_kind and row_end; is_last_res marks the final element.
//   A registered output stage holds a stalled transaction; the sequencer
//   waits on it and does not drop or repeat elements.
//   Reset clears the element count and all control state; the block then
//   accepts a new sequence at once.
// ----------------------------------------------------------------------------
module prev_next_permutation #(
	parameter int MAX_LEN = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pnp_pkg::VAL_W-1:0]  value,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pnp_pkg::VAL_W-1:0]  value_res,
	output logic [pnp_pkg::KIND_W-1:0] row_kind,
	output logic                       row_end,
	output logic                       is_last_res
);
	import pnp_pkg::*;

	emit_t             emit;
	logic              out_free;
	logic              out_valid_q;
	logic [VAL_W-1:0]  value_res_q;
	logic [KIND_W-1:0] row_kind_q;
	logic              row_end_q;
	logic              is_last_res_q;

	assign out_free = !out_valid_q || !out_stall;

	pnp_seq #(
		.MAX_LEN (MAX_LEN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.value    (value),
		.is_last  (is_last),
		.in_stall (in_stall),
		.out_free (out_free),
		.emit     (emit)
	);

	// hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the output payload
	always_ff @(posedge clk) begin
		if (emit.load) begin
			value_res_q   <= emit.value;
			row_kind_q    <= emit.kind;
			row_end_q     <= emit.row_end;
			is_last_res_q <= emit.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_res   = value_res_q;
	assign row_kind    = row_kind_q;
	assign row_end     = row_end_q;
	assign is_last_res = is_last_res_q;

`ifndef SYNTH
	// never overwrite an output transaction that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

	// the final element of a run always closes a row
	a_last_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_last_res_q) |-> row_end_q)
		else $error("final result not on a row end");

	// no element is emitted while input is being taken
	a_load_xor_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !emit.load)
		else $error("emit during load");

	// an output transaction that follows an idle output carries a defined row kind
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (row_kind_q != 2'd3))
		else $error("illegal row kind");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for prev_next_permutation. It loads sequences through
// the input channel and predicts the previous row, original row and next row
// of each one. Every output transaction is compared field by field with the
// oldest predicted element. Covered: directed extremes, single elements,
// sorted and all-equal runs, overflow past the store, and random sequences
// under changing sender gaps and receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;

	import pnp_pkg::*;

	localparam int SEQ_MAX     = 16;
	localparam int TOTAL_ITEMS = 230;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [KIND_W-1:0] kind;
		logic              row_end;
		logic              last;
	} row_elem_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [VAL_W-1:0]  value = '0;
	logic              is_last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VAL_W-1:0]  value_res;
	logic [KIND_W-1:0] row_kind;
	logic              row_end;
	logic              is_last_res;

	// predictor state: loaded sequence and a scratch row for permuting
	logic [VAL_W-1:0] seq_buf [SEQ_MAX];
	logic [VAL_W-1:0] scratch [SEQ_MAX];
	int               seq_cnt = 0;
	row_elem_t        expected_rows[$];
	row_elem_t        want;

	int fail_count = 0;
	int items_sent = 0;

	// sender and receiver idling knobs
	int gap_max    = 0;
	int burst_left = 0;
	int stall_pct  = 0;
	int stall_run  = 0;
	logic stall_now = 1'b0;

	prev_next_permutation #(
		.MAX_LEN(SEQ_MAX)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value_res  (value_res),
		.row_kind   (row_kind),
		.row_end    (row_end),
		.is_last_res(is_last_res)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Step scratch[0..n-1] to its previous (up = 0) or next (up = 1)
	// arrangement with strict compares; return 0 when none exists.
	function automatic bit permute_scratch(input int n, input bit up);
		int               i;
		int               j;
		logic [VAL_W-1:0] t;
		if (n < 2)
			return 1'b0;
		// find the pivot: the element just before the longest monotone suffix
		i = n - 1;
		while (up ? !(scratch[i-1] < scratch[i]) : !(scratch[i-1] > scratch[i])) begin
			i--;
			if (i == 0)
				return 1'b0;
		end
		i--;
		// swap with the nearest larger or smaller suffix value
		j = n - 1;
		while (up ? !(scratch[j] > scratch[i]) : !(scratch[j] < scratch[i]))
			j--;
		t = scratch[i];
		scratch[i] = scratch[j];
		scratch[j] = t;
		// reverse the suffix
		i++;
		j = n - 1;
		while (i < j) begin
			t = scratch[i];
			scratch[i] = scratch[j];
			scratch[j] = t;
			i++;
			j--;
		end
		return 1'b1;
	endfunction

	// Queue one row: the original comes from the loaded sequence, the others
	// from the scratch row.
	task automatic push_row(input logic [KIND_W-1:0] kind, input logic closes_run);
		row_elem_t e;
		for (int k = 0; k < seq_cnt; k++) begin
			e.value   = (kind == KIND_ORIG) ? seq_buf[k] : scratch[k];
			e.kind    = kind;
			e.row_end = (k == seq_cnt - 1);
			e.last    = closes_run && e.row_end;
			expected_rows.push_back(e);
		end
	endtask

	// Update the predictor with one accepted element; on the last mark
	// queue the rows it produces.
	task automatic load_element(input logic [VAL_W-1:0] v, input logic last);
		bit has_next;
		if (seq_cnt < SEQ_MAX) begin
			seq_buf[seq_cnt] = v;
			seq_cnt++;
		end
		if (last) begin
			for (int k = 0; k < SEQ_MAX; k++)
				scratch[k] = seq_buf[k];
			if (permute_scratch(seq_cnt, 1'b0))
				push_row(KIND_PREV, 1'b0);
			for (int k = 0; k < SEQ_MAX; k++)
				scratch[k] = seq_buf[k];
			has_next = permute_scratch(seq_cnt, 1'b1);
			push_row(KIND_ORIG, !has_next);
			if (has_next)
				push_row(KIND_NEXT, 1'b1);
			seq_cnt = 0;
		end
	endtask

	// Send one element; idle between bursts of random length.
	task automatic send_element(input logic [VAL_W-1:0] v, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		value    <= v;
		is_last  <= last;
		// hold until the transaction is taken
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		load_element(v, last);
		items_sent++;
	endtask

	// Receiver stall pattern: runs of stall or no stall of random length.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(1, 10);
			stall_now = ($urandom_range(0, 99) < stall_pct);
		end
		stall_run--;
		out_stall <= stall_now;
	end

	// Check each output transaction against the oldest predicted element.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got value_res=%h kind=%0d",
					$time, value_res, row_kind);
				fail_count++;
			end else begin
				want = expected_rows.pop_front();
				if (value_res !== want.value) begin
					$display("%0t: value_res expected %h got %h", $time, want.value, value_res);
					fail_count++;
				end
				if (row_kind !== want.kind) begin
					$display("%0t: row_kind expected %0d got %0d", $time, want.kind, row_kind);
					fail_count++;
				end
				if (row_end !== want.row_end) begin
					$display("%0t: row_end expected %b got %b", $time, want.row_end, row_end);
					fail_count++;
				end
				if (is_last_res !== want.last) begin
					$display("%0t: is_last_res expected %b got %b", $time, want.last, is_last_res);
					fail_count++;
				end
			end
		end
	end

	// Single element at the top of the range: original row only.
	task automatic test_single_element;
		send_element(16'hFFFF, 1'b1);
	endtask

	// Smallest and largest arrangements: one side of the pair is left out.
	task automatic test_sorted_extremes;
		send_element(16'h0000, 1'b0);
		send_element(16'hFFFF, 1'b1);
		send_element(16'hFFFF, 1'b0);
		send_element(16'h8000, 1'b0);
		send_element(16'h0000, 1'b1);
	endtask

	// All values equal: no pivot either way.
	task automatic test_all_equal;
		send_element(16'h5A5A, 1'b0);
		send_element(16'h5A5A, 1'b0);
		send_element(16'h5A5A, 1'b1);
	endtask

	// One element past the store, carrying the last mark: it is dropped.
	task automatic test_overflow;
		for (int k = 0; k <= SEQ_MAX; k++)
			send_element(VAL_W'(k * 3851 + 7), k == SEQ_MAX);
	endtask

	// Random sequences under rotating idle settings.
	task automatic test_random_sequences;
		int               len;
		int               mode;
		int               r;
		logic [VAL_W-1:0] base;
		logic [VAL_W-1:0] v;
		while (items_sent < TOTAL_ITEMS) begin
			case ((items_sent / 40) % 4)
				0: begin gap_max = 0; stall_pct = 0;  end
				1: begin gap_max = 3; stall_pct = 30; end
				2: begin gap_max = 8; stall_pct = 70; end
				default: begin gap_max = 1; stall_pct = 10; end
			endcase
			// mostly short sequences, some full, a few past the store
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 6);
			else if (r < 92)
				len = $urandom_range(7, SEQ_MAX);
			else
				len = $urandom_range(SEQ_MAX + 1, SEQ_MAX + 4);
			mode = $urandom_range(0, 4);
			base = VAL_W'($urandom_range(0, 16'hFFFF - 24));
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: v = VAL_W'($urandom_range(0, 16'hFFFF));
					1: v = VAL_W'($urandom_range(0, 3));
					2: case ($urandom_range(0, 3))
						0: v = 16'h0000;
						1: v = 16'hFFFF;
						2: v = 16'h8000;
						default: v = 16'h7FFF;
					endcase
					3: v = base + VAL_W'(k);
					default: v = base + VAL_W'(len - k);
				endcase
				send_element(v, k == len - 1);
			end
		end
	endtask

	// Main sequence
	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		gap_max   = 2;
		stall_pct = 25;
		test_single_element();
		test_sorted_extremes();
		test_all_equal();
		test_overflow();
		test_random_sequences();
		@(negedge clk);
		in_valid <= 1'b0;
		// drain, then watch for stray transactions
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule
